// ===== hdl/tcpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpc_pkg
// Shared types and constants for the tcp client connection control block.
// ----------------------------------------------------------------------------
package tcpc_pkg;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_ESTABLISHED = 3'd2,
        ST_FIN_WAIT1   = 3'd3,
        ST_FIN_WAIT2   = 3'd4,
        ST_TIME_WAIT   = 3'd5
    } conn_state_t;

    localparam logic [1:0] KIND_CONNECT = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;

    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_RST_BIT = 2;
    localparam int unsigned FLAG_ACK_BIT = 4;

    localparam logic [7:0] FLAGS_SYN     = 8'h02;
    localparam logic [7:0] FLAGS_ACK     = 8'h10;
    localparam logic [7:0] FLAGS_FIN_ACK = 8'h11;

    localparam logic [15:0] CLIENT_PORT  = 16'd44000;
    localparam logic [15:0] HEADER_BYTES = 16'd20;
    localparam logic [15:0] WINDOW_SIZE  = 16'd4096;
    localparam logic [15:0] PROTO_TCP    = 16'd6;
    localparam logic [15:0] DATA_OFFSET  = 16'h5000;

    localparam int unsigned SUM_W = 20;

    localparam logic [0:0] CFG_OWN_IP  = 1'b0;
    localparam logic [0:0] CFG_MAC_LOW = 1'b1;

endpackage : tcpc_pkg
`default_nettype wire

// ===== hdl/tcpc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcpc_if
// Event and result item channels of the tcp client connection control block.
// ----------------------------------------------------------------------------
interface tcpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [7:0]  rx_flags;
    logic [31:0] rx_seq;
    logic [15:0] rx_length;
    logic [31:0] tick_count;

    modport source (
        output valid, kind, peer_ip, peer_port, rx_flags, rx_seq, rx_length, tick_count,
        input  ready
    );
    modport sink (
        input  valid, kind, peer_ip, peer_port, rx_flags, rx_seq, rx_length, tick_count,
        output ready
    );
endinterface : tcpc_in_if

interface tcpc_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  tx_flags;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [15:0] tx_source_port;
    logic [15:0] tx_dest_port;
    logic [31:0] tx_dst_ip;
    logic [15:0] tx_checksum;
    logic [2:0]  conn_state;
    logic        rejected;

    modport source (
        output valid, send_valid, tx_flags, tx_seq, tx_ack, tx_source_port, tx_dest_port,
               tx_dst_ip, tx_checksum, conn_state, rejected,
        input  ready
    );
    modport sink (
        input  valid, send_valid, tx_flags, tx_seq, tx_ack, tx_source_port, tx_dest_port,
               tx_dst_ip, tx_checksum, conn_state, rejected,
        output ready
    );
endinterface : tcpc_out_if
`default_nettype wire

// ===== hdl/tcp_client_connection_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm
// Single-connection tcp client control machine with control segment builder.
// ----------------------------------------------------------------------------
// Takes connect, close and received-segment events and returns one result item
// per event: the connection state after the event, a connect-refused flag and,
// when a SYN, ACK or FIN+ACK control segment is due, its header fields and
// checksum. One item is accepted per cycle while the result side is not stalled;
// each item passes an input register, a decision stage that updates the
// connection state and forms the header sum, and a fold stage that finishes
// the checksum into the output register. Stalls on the result side back up
// through the stages. Configuration writes are to be taken only while no item
// is in flight; the user must ensure this, as the block does not enforce it.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        write_en,
    input  wire logic [0:0]  write_index,
    input  wire logic [31:0] write_data,
    tcpc_in_if.sink          in_item,
    tcpc_out_if.source       out_item
);
    import tcpc_pkg::*;

    // configuration
    logic [31:0] own_ip_reg;
    logic [31:0] mac_low_reg;

    // connection state
    conn_state_t state_reg, state_next;
    logic [31:0] remote_ip_reg, remote_ip_next;
    logic [15:0] remote_port_reg, remote_port_next;
    logic [15:0] client_port_reg, client_port_next;
    logic [31:0] send_seq_reg, send_seq_next;
    logic [31:0] expect_seq_reg, expect_seq_next;

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [31:0] s1_peer_ip_reg;
    logic [15:0] s1_peer_port_reg;
    logic [7:0]  s1_flags_reg;
    logic [31:0] s1_rx_seq_reg;
    logic [15:0] s1_rx_length_reg;
    logic [31:0] s1_tick_reg;

    // decision stage
    logic             s2_valid_reg;
    logic             s2_send_reg;
    logic [7:0]       s2_flags_reg;
    logic [31:0]      s2_seq_reg;
    logic [31:0]      s2_ack_reg;
    logic [15:0]      s2_source_port_reg;
    logic [15:0]      s2_dest_port_reg;
    logic [31:0]      s2_dst_ip_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    conn_state_t      s2_state_reg;
    logic             s2_rejected_reg;

    // output stage
    logic        s3_valid_reg;
    logic        s3_send_reg;
    logic [7:0]  s3_flags_reg;
    logic [31:0] s3_seq_reg;
    logic [31:0] s3_ack_reg;
    logic [15:0] s3_source_port_reg;
    logic [15:0] s3_dest_port_reg;
    logic [31:0] s3_dst_ip_reg;
    logic [15:0] s3_checksum_reg;
    conn_state_t s3_state_reg;
    logic        s3_rejected_reg;

    // flow control
    logic out_free, s2_free, s1_free, s1_fire;

    assign out_free      = !s3_valid_reg || out_item.ready;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s1_fire       = s1_valid_reg && s2_free;
    assign in_item.ready = s1_free;

    // event decode
    logic        is_connect, is_close, seg_take;
    logic        rx_fin, rx_syn, rx_rst, rx_ack;
    logic        emit_syn, emit_fin, emit_ack, do_send, reject;
    logic [31:0] isn, rx_seq_inc;

    assign rx_fin     = s1_flags_reg[FLAG_FIN_BIT];
    assign rx_syn     = s1_flags_reg[FLAG_SYN_BIT];
    assign rx_rst     = s1_flags_reg[FLAG_RST_BIT];
    assign rx_ack     = s1_flags_reg[FLAG_ACK_BIT];
    assign is_connect = (s1_kind_reg == KIND_CONNECT);
    assign is_close   = (s1_kind_reg == KIND_CLOSE);
    assign seg_take   = (s1_kind_reg == KIND_SEGMENT) && (s1_rx_length_reg >= HEADER_BYTES)
                        && (state_reg != ST_CLOSED) && (s1_peer_port_reg == remote_port_reg)
                        && (s1_peer_ip_reg == remote_ip_reg);
    assign isn        = s1_tick_reg ^ mac_low_reg;
    assign rx_seq_inc = s1_rx_seq_reg + 32'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLOSED:
            begin
                if (is_connect)
                    state_next = ST_SYN_SENT;
            end
            ST_SYN_SENT:
            begin
                if (seg_take && rx_syn && rx_ack)
                    state_next = ST_ESTABLISHED;
                else if (seg_take && rx_rst)
                    state_next = ST_CLOSED;
            end
            ST_ESTABLISHED:
            begin
                if (is_close)
                    state_next = ST_FIN_WAIT1;
            end
            ST_FIN_WAIT1:
            begin
                if (seg_take && rx_fin)
                    state_next = ST_TIME_WAIT;
                else if (seg_take && rx_ack)
                    state_next = ST_FIN_WAIT2;
            end
            ST_FIN_WAIT2:
            begin
                if (seg_take && rx_fin)
                    state_next = ST_TIME_WAIT;
            end
            ST_TIME_WAIT:
            begin
                state_next = ST_TIME_WAIT;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // segment fields
    logic [7:0]       tx_flags_c;
    logic [31:0]      tx_seq_c, tx_ack_c;
    logic [SUM_W-1:0] sum_c;

    always_comb
    begin
        emit_syn = is_connect && (state_reg == ST_CLOSED);
        emit_fin = is_close && (state_reg == ST_ESTABLISHED);
        emit_ack = seg_take && (((state_reg == ST_SYN_SENT) && rx_syn && rx_ack)
                   || (((state_reg == ST_FIN_WAIT1) || (state_reg == ST_FIN_WAIT2)) && rx_fin));
        do_send  = emit_syn || emit_fin || emit_ack;
        reject   = is_connect && (state_reg != ST_CLOSED);

        remote_ip_next   = emit_syn ? s1_peer_ip_reg   : remote_ip_reg;
        remote_port_next = emit_syn ? s1_peer_port_reg : remote_port_reg;
        client_port_next = emit_syn ? CLIENT_PORT      : client_port_reg;

        send_seq_next = send_seq_reg;
        if (emit_syn)
            send_seq_next = isn + 32'd1;
        else if (emit_fin)
            send_seq_next = send_seq_reg + 32'd1;

        expect_seq_next = expect_seq_reg;
        if (emit_syn)
            expect_seq_next = '0;
        else if (emit_ack)
            expect_seq_next = rx_seq_inc;

        if (emit_syn)
        begin
            tx_flags_c = FLAGS_SYN;
            tx_seq_c   = isn;
            tx_ack_c   = '0;
        end
        else if (emit_fin)
        begin
            tx_flags_c = FLAGS_FIN_ACK;
            tx_seq_c   = send_seq_reg;
            tx_ack_c   = expect_seq_reg;
        end
        else
        begin
            tx_flags_c = FLAGS_ACK;
            tx_seq_c   = send_seq_reg;
            tx_ack_c   = rx_seq_inc;
        end

        sum_c = SUM_W'(own_ip_reg[31:16]) + SUM_W'(own_ip_reg[15:0])
              + SUM_W'(remote_ip_next[31:16]) + SUM_W'(remote_ip_next[15:0])
              + SUM_W'(PROTO_TCP) + SUM_W'(HEADER_BYTES)
              + SUM_W'(client_port_next) + SUM_W'(remote_port_next)
              + SUM_W'(tx_seq_c[31:16]) + SUM_W'(tx_seq_c[15:0])
              + SUM_W'(tx_ack_c[31:16]) + SUM_W'(tx_ack_c[15:0])
              + SUM_W'(DATA_OFFSET | {8'h00, tx_flags_c}) + SUM_W'(WINDOW_SIZE);
    end

    // checksum fold
    logic [16:0] fold1_c;
    logic [15:0] fold2_c;

    assign fold1_c = 17'(s2_sum_reg[15:0]) + 17'(s2_sum_reg[SUM_W-1:16]);
    assign fold2_c = fold1_c[15:0] + 16'(fold1_c[16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            mac_low_reg <= '0;
        end
        else if (write_en)
        begin
            unique case (write_index)
                CFG_OWN_IP:  own_ip_reg  <= write_data;
                CFG_MAC_LOW: mac_low_reg <= write_data;
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLOSED;
            remote_ip_reg   <= '0;
            remote_port_reg <= '0;
            client_port_reg <= '0;
            send_seq_reg    <= '0;
            expect_seq_reg  <= '0;
        end
        else if (s1_fire)
        begin
            state_reg       <= state_next;
            remote_ip_reg   <= remote_ip_next;
            remote_port_reg <= remote_port_next;
            client_port_reg <= client_port_next;
            send_seq_reg    <= send_seq_next;
            expect_seq_reg  <= expect_seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_item.valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_item.valid)
        begin
            s1_kind_reg      <= in_item.kind;
            s1_peer_ip_reg   <= in_item.peer_ip;
            s1_peer_port_reg <= in_item.peer_port;
            s1_flags_reg     <= in_item.rx_flags;
            s1_rx_seq_reg    <= in_item.rx_seq;
            s1_rx_length_reg <= in_item.rx_length;
            s1_tick_reg      <= in_item.tick_count;
        end
        if (s1_fire)
        begin
            s2_send_reg        <= do_send;
            s2_flags_reg       <= do_send ? tx_flags_c       : '0;
            s2_seq_reg         <= do_send ? tx_seq_c         : '0;
            s2_ack_reg         <= do_send ? tx_ack_c         : '0;
            s2_source_port_reg <= do_send ? client_port_next : '0;
            s2_dest_port_reg   <= do_send ? remote_port_next : '0;
            s2_dst_ip_reg      <= do_send ? remote_ip_next   : '0;
            s2_sum_reg         <= sum_c;
            s2_state_reg       <= state_next;
            s2_rejected_reg    <= reject;
        end
        if (out_free && s2_valid_reg)
        begin
            s3_send_reg        <= s2_send_reg;
            s3_flags_reg       <= s2_flags_reg;
            s3_seq_reg         <= s2_seq_reg;
            s3_ack_reg         <= s2_ack_reg;
            s3_source_port_reg <= s2_source_port_reg;
            s3_dest_port_reg   <= s2_dest_port_reg;
            s3_dst_ip_reg      <= s2_dst_ip_reg;
            s3_checksum_reg    <= s2_send_reg ? ~fold2_c : '0;
            s3_state_reg       <= s2_state_reg;
            s3_rejected_reg    <= s2_rejected_reg;
        end
    end

    assign out_item.valid          = s3_valid_reg;
    assign out_item.send_valid     = s3_send_reg;
    assign out_item.tx_flags       = s3_flags_reg;
    assign out_item.tx_seq         = s3_seq_reg;
    assign out_item.tx_ack         = s3_ack_reg;
    assign out_item.tx_source_port = s3_source_port_reg;
    assign out_item.tx_dest_port   = s3_dest_port_reg;
    assign out_item.tx_dst_ip      = s3_dst_ip_reg;
    assign out_item.tx_checksum    = s3_checksum_reg;
    assign out_item.conn_state     = 3'(s3_state_reg);
    assign out_item.rejected       = s3_rejected_reg;

endmodule : tcp_client_connection_fsm
`default_nettype wire

// ===== tb/sv/tcp_client_connection_fsm_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm_test
// Self-checking bench for the tcp client connection control block.
// ----------------------------------------------------------------------------
// Connect, close and received-segment items go in through a queue-fed driver
// with random gaps; a scoreboard tracks the connection the same way the block
// should and checks every result item field by field: state, refusals, and
// the header fields and checksum of each SYN, ACK or FIN+ACK segment. Runs
// a short directed sweep, then many connect/reset handshakes under several
// register settings, and ends with one full close down to time wait.
// ----------------------------------------------------------------------------
module tcp_client_connection_fsm_test;
    import tcpc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_CYCLES  = 150;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [7:0] FIN_MASK = 8'(1 << FLAG_FIN_BIT);
    localparam logic [7:0] SYN_MASK = 8'(1 << FLAG_SYN_BIT);
    localparam logic [7:0] RST_MASK = 8'(1 << FLAG_RST_BIT);
    localparam logic [7:0] ACK_MASK = 8'(1 << FLAG_ACK_BIT);

    typedef enum int {PEER_ACKS_FIRST, PEER_FIN_ACK, PEER_FIN_ONLY} teardown_kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [7:0]  rx_flags;
        logic [31:0] rx_seq;
        logic [15:0] rx_length;
        logic [31:0] tick_count;
    } conn_event_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  tx_flags;
        logic [31:0] tx_seq;
        logic [31:0] tx_ack;
        logic [15:0] tx_source_port;
        logic [15:0] tx_dest_port;
        logic [31:0] tx_dst_ip;
        logic [15:0] tx_checksum;
        logic [2:0]  conn_state;
        logic        rejected;
    } conn_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        write_en;
    logic [0:0]  write_index;
    logic [31:0] write_data;

    tcpc_in_if  in_ch ();
    tcpc_out_if out_ch ();

    tcp_client_connection_fsm dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .in_item     (in_ch),
        .out_item    (out_ch)
    );

    always #5 clk = ~clk;

    // tracked connection
    conn_state_t link_state  = ST_CLOSED;
    logic [31:0] peer_addr   = '0;
    logic [15:0] peer_port_q = '0;
    logic [15:0] our_port    = '0;
    logic [31:0] snd_nxt     = '0;
    logic [31:0] rcv_nxt     = '0;
    logic [31:0] own_ip_cfg  = '0;
    logic [31:0] mac_cfg     = '0;

    conn_event_t  queued_events[$];
    conn_result_t predicted_replies[$];

    int   items_queued   = 0;
    int   failures       = 0;
    int   items_checked  = 0;
    int   segments_sent  = 0;
    int   refusals       = 0;
    int   zero_sums      = 0;
    logic [7:0] states_seen = '0;
    int   cycle_count    = 0;
    bit   no_idle        = 1'b0;
    int   holds_asked    = 0;
    int   holds_served   = 0;
    int   hold_left      = 0;

    function automatic logic [15:0] header_checksum(input logic [31:0] src_ip,
                                                    input logic [31:0] dst_ip,
                                                    input logic [15:0] source_port,
                                                    input logic [15:0] dest_port,
                                                    input logic [31:0] seq,
                                                    input logic [31:0] ack,
                                                    input logic [7:0]  flags);
        logic [31:0] acc;
        acc = 32'(src_ip[31:16]) + 32'(src_ip[15:0]) + 32'(dst_ip[31:16])
            + 32'(dst_ip[15:0]) + 32'(PROTO_TCP) + 32'(HEADER_BYTES)
            + 32'(source_port) + 32'(dest_port) + 32'(seq[31:16]) + 32'(seq[15:0])
            + 32'(ack[31:16]) + 32'(ack[15:0]) + 32'(DATA_OFFSET | 16'(flags))
            + 32'(WINDOW_SIZE);
        while (acc[31:16] != 16'h0)
            acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    function automatic conn_result_t advance_connection(input conn_event_t ev);
        conn_result_t r;
        logic         fire;
        logic [7:0]   flags;
        logic [31:0]  seq;
        logic [31:0]  ack;
        r     = '0;
        fire  = 1'b0;
        flags = '0;
        seq   = '0;
        ack   = '0;
        case (ev.kind)
            KIND_CONNECT:
            begin
                if (link_state != ST_CLOSED)
                    r.rejected = 1'b1;
                else
                begin
                    peer_addr   = ev.peer_ip;
                    peer_port_q = ev.peer_port;
                    our_port    = CLIENT_PORT;
                    rcv_nxt     = '0;
                    seq         = ev.tick_count ^ mac_cfg;
                    snd_nxt     = seq + 32'd1;
                    fire        = 1'b1;
                    flags       = FLAGS_SYN;
                    link_state  = ST_SYN_SENT;
                end
            end
            KIND_CLOSE:
            begin
                if (link_state == ST_ESTABLISHED)
                begin
                    fire       = 1'b1;
                    flags      = FLAGS_FIN_ACK;
                    seq        = snd_nxt;
                    ack        = rcv_nxt;
                    snd_nxt    = snd_nxt + 32'd1;
                    link_state = ST_FIN_WAIT1;
                end
            end
            KIND_SEGMENT:
            begin
                if (ev.rx_length >= HEADER_BYTES && link_state != ST_CLOSED &&
                    ev.peer_port == peer_port_q && ev.peer_ip == peer_addr)
                begin
                    if (link_state == ST_SYN_SENT)
                    begin
                        if (ev.rx_flags[FLAG_SYN_BIT] && ev.rx_flags[FLAG_ACK_BIT])
                        begin
                            rcv_nxt    = ev.rx_seq + 32'd1;
                            fire       = 1'b1;
                            flags      = FLAGS_ACK;
                            seq        = snd_nxt;
                            ack        = rcv_nxt;
                            link_state = ST_ESTABLISHED;
                        end
                        else if (ev.rx_flags[FLAG_RST_BIT])
                            link_state = ST_CLOSED;
                    end
                    else if (link_state == ST_FIN_WAIT1 || link_state == ST_FIN_WAIT2)
                    begin
                        if (link_state == ST_FIN_WAIT1 && ev.rx_flags[FLAG_ACK_BIT])
                            link_state = ST_FIN_WAIT2;
                        if (ev.rx_flags[FLAG_FIN_BIT])
                        begin
                            rcv_nxt    = ev.rx_seq + 32'd1;
                            fire       = 1'b1;
                            flags      = FLAGS_ACK;
                            seq        = snd_nxt;
                            ack        = rcv_nxt;
                            link_state = ST_TIME_WAIT;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        if (fire)
        begin
            r.send_valid     = 1'b1;
            r.tx_flags       = flags;
            r.tx_seq         = seq;
            r.tx_ack         = ack;
            r.tx_source_port = our_port;
            r.tx_dest_port   = peer_port_q;
            r.tx_dst_ip      = peer_addr;
            r.tx_checksum    = header_checksum(own_ip_cfg, peer_addr, our_port, peer_port_q,
                                               seq, ack, flags);
        end
        r.conn_state = link_state;
        return r;
    endfunction

    // stimulus helpers

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = 32'h0;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] long_len();
        return ($urandom_range(3) == 0) ? HEADER_BYTES : 16'($urandom_range(65535, 20));
    endfunction

    function automatic conn_event_t any_event();
        conn_event_t e;
        e.kind       = 2'($urandom_range(3));
        e.peer_ip    = $urandom;
        e.peer_port  = 16'($urandom);
        e.rx_flags   = 8'($urandom);
        e.rx_seq     = $urandom;
        e.rx_length  = 16'($urandom);
        e.tick_count = $urandom;
        return e;
    endfunction

    function automatic conn_event_t segment_from(input logic [31:0] ip,
                                                 input logic [15:0] port,
                                                 input logic [7:0]  flags,
                                                 input logic [15:0] len);
        conn_event_t e;
        e           = any_event();
        e.kind      = KIND_SEGMENT;
        e.peer_ip   = ip;
        e.peer_port = port;
        e.rx_flags  = flags;
        e.rx_length = len;
        return e;
    endfunction

    function automatic conn_event_t connect_to(input logic [31:0] ip,
                                               input logic [15:0] port,
                                               input logic [31:0] ticks);
        conn_event_t e;
        e            = any_event();
        e.kind       = KIND_CONNECT;
        e.peer_ip    = ip;
        e.peer_port  = port;
        e.tick_count = ticks;
        return e;
    endfunction

    // items that leave a half-open connection where it is
    function automatic conn_event_t syn_sent_noise(input logic [31:0] ip,
                                                   input logic [15:0] port);
        conn_event_t e;
        logic [7:0]  f;
        f = 8'($urandom) & ~RST_MASK;
        if ((f & SYN_MASK) != 8'h0)
            f = f & ~ACK_MASK;
        case ($urandom_range(4))
            0:       e = any_event();
            1:       e = segment_from(ip, port, 8'($urandom), 16'($urandom_range(19)));
            2:       e = segment_from(ip, port, f, long_len());
            3:       e = segment_from(ip ^ (32'h1 << $urandom_range(31)), port,
                                      8'($urandom), long_len());
            default: e = segment_from(ip, port ^ (16'h1 << $urandom_range(15)),
                                      8'($urandom), long_len());
        endcase
        return e;
    endfunction

    task automatic queue_event(input conn_event_t e);
        queued_events.push_back(e);
        items_queued++;
    endtask

    task automatic set_register(input logic [0:0] index, input logic [31:0] value);
        @(posedge clk);
        write_en    <= 1'b1;
        write_index <= index;
        write_data  <= value;
        @(posedge clk);
        write_en    <= 1'b0;
        if (index == CFG_OWN_IP)
            own_ip_cfg = value;
        else
            mac_cfg = value;
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (queued_events.size() != 0 || in_ch.valid || predicted_replies.size() != 0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : sender
        conn_event_t ev;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (queued_events.size() != 0 && (no_idle || $urandom_range(99) >= 30))
            begin
                ev = queued_events.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.kind       <= ev.kind;
                in_ch.peer_ip    <= ev.peer_ip;
                in_ch.peer_port  <= ev.peer_port;
                in_ch.rx_flags   <= ev.rx_flags;
                in_ch.rx_seq     <= ev.rx_seq;
                in_ch.rx_length  <= ev.rx_length;
                in_ch.tick_count <= ev.tick_count;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result side readiness, with long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
            out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : scoreboard
        conn_result_t want;
        conn_event_t  taken;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                items_checked++;
                if (predicted_replies.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    failures++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    compare_field("send_valid", want.send_valid, out_ch.send_valid);
                    compare_field("tx_flags", want.tx_flags, out_ch.tx_flags);
                    compare_field("tx_seq", want.tx_seq, out_ch.tx_seq);
                    compare_field("tx_ack", want.tx_ack, out_ch.tx_ack);
                    compare_field("tx_source_port", want.tx_source_port,
                                  out_ch.tx_source_port);
                    compare_field("tx_dest_port", want.tx_dest_port, out_ch.tx_dest_port);
                    compare_field("tx_dst_ip", want.tx_dst_ip, out_ch.tx_dst_ip);
                    compare_field("tx_checksum", want.tx_checksum, out_ch.tx_checksum);
                    compare_field("conn_state", want.conn_state, out_ch.conn_state);
                    compare_field("rejected", want.rejected, out_ch.rejected);
                    states_seen[want.conn_state] = 1'b1;
                    if (want.send_valid)
                        segments_sent++;
                    if (want.send_valid && want.tx_checksum == 16'h0)
                        zero_sums++;
                    if (want.rejected)
                        refusals++;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                taken.kind       = in_ch.kind;
                taken.peer_ip    = in_ch.peer_ip;
                taken.peer_port  = in_ch.peer_port;
                taken.rx_flags   = in_ch.rx_flags;
                taken.rx_seq     = in_ch.rx_seq;
                taken.rx_length  = in_ch.rx_length;
                taken.tick_count = in_ch.tick_count;
                predicted_replies.push_back(advance_connection(taken));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d items queued and %0d results outstanding",
                     queued_events.size(), predicted_replies.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        conn_event_t    e;
        logic [31:0]    ip;
        logic [15:0]    port;
        logic [7:0]     flags;
        teardown_kind_t how;
        int             phase_start;
        rst_n            = 1'b0;
        write_en         = 1'b0;
        write_index      = '0;
        write_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = '0;
        in_ch.peer_ip    = '0;
        in_ch.peer_port  = '0;
        in_ch.rx_flags   = '0;
        in_ch.rx_seq     = '0;
        in_ch.rx_length  = '0;
        in_ch.tick_count = '0;
        out_ch.ready     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_register(CFG_OWN_IP, 32'hFFFF_FFFF);
        set_register(CFG_MAC_LOW, 32'h0);
        @(negedge clk);

        // directed sweep
        queue_event(segment_from(32'h0, 16'h0, 8'hFF, HEADER_BYTES));
        e = any_event();
        e.kind = KIND_CLOSE;
        queue_event(e);
        e = any_event();
        e.kind = KIND_UNKNOWN;
        queue_event(e);
        queue_event(connect_to(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        queue_event(connect_to($urandom, 16'($urandom), $urandom));
        queue_event(segment_from(32'hFFFF_FFFF, 16'hFFFF, SYN_MASK | ACK_MASK, 16'd19));
        queue_event(segment_from(32'hFFFF_FFFF, 16'hFFFE, SYN_MASK | ACK_MASK, HEADER_BYTES));
        queue_event(segment_from(32'h7FFF_FFFF, 16'hFFFF, SYN_MASK | ACK_MASK, HEADER_BYTES));
        queue_event(segment_from(32'hFFFF_FFFF, 16'hFFFF, SYN_MASK, HEADER_BYTES));
        queue_event(segment_from(32'hFFFF_FFFF, 16'hFFFF, FIN_MASK | ACK_MASK, HEADER_BYTES));
        queue_event(segment_from(32'hFFFF_FFFF, 16'hFFFF, RST_MASK, 16'hFFFF));
        // sequence picked so the folded sum is all ones
        queue_event(connect_to(32'h0, 16'h0,
                               {16'h0, header_checksum(own_ip_cfg, 32'h0, CLIENT_PORT, 16'h0,
                                                       32'h0, 32'h0, FLAGS_SYN)} ^ mac_cfg));
        e = any_event();
        e.kind = KIND_CLOSE;
        queue_event(e);
        queue_event(segment_from(32'h0, 16'h0, RST_MASK | SYN_MASK, 16'hFFFF));

        // connect and reset handshakes under several register settings
        for (int p = 0; p < 8; p++)
        begin
            wait_for_drain();
            case (p)
                0:
                begin
                    set_register(CFG_OWN_IP, 32'h0);
                    set_register(CFG_MAC_LOW, 32'hFFFF_FFFF);
                end
                1:
                begin
                    set_register(CFG_OWN_IP, 32'hFFFF_FFFF);
                    set_register(CFG_MAC_LOW, 32'hFFFF_FFFF);
                end
                2:
                begin
                    set_register(CFG_OWN_IP, 32'h0);
                    set_register(CFG_MAC_LOW, 32'h0);
                end
                default:
                begin
                    set_register(CFG_OWN_IP, $urandom);
                    set_register(CFG_MAC_LOW, $urandom);
                end
            endcase
            @(negedge clk);
            no_idle = (p == 2);
            if (p == 5)
                holds_asked++;
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
            begin
                ip   = pick_word();
                port = 16'(pick_word());
                if ($urandom_range(1) == 0)
                begin
                    e = any_event();
                    if (e.kind == KIND_CONNECT)
                        e.kind = KIND_SEGMENT;
                    queue_event(e);
                end
                queue_event(connect_to(ip, port, pick_word()));
                repeat ($urandom_range(3)) queue_event(syn_sent_noise(ip, port));
                flags = 8'($urandom) | RST_MASK;
                flags = flags & (($urandom_range(1) == 0) ? ~ACK_MASK : ~SYN_MASK);
                queue_event(segment_from(ip, port, flags, long_len()));
            end
        end

        // one full open and close, ending in time wait
        wait_for_drain();
        set_register(CFG_OWN_IP, $urandom);
        set_register(CFG_MAC_LOW, $urandom);
        @(negedge clk);
        no_idle = 1'b0;
        ip   = pick_word();
        port = 16'(pick_word());
        queue_event(connect_to(ip, port, pick_word()));
        repeat ($urandom_range(3)) queue_event(syn_sent_noise(ip, port));
        e = segment_from(ip, port, 8'($urandom) | SYN_MASK | ACK_MASK, long_len());
        e.rx_seq = pick_word();
        queue_event(e);
        repeat (12)
        begin
            e = ($urandom_range(1) == 0) ? segment_from(ip, port, 8'($urandom), 16'($urandom))
                                         : any_event();
            if (e.kind == KIND_CLOSE)
                e.kind = KIND_CONNECT;
            queue_event(e);
        end
        e = any_event();
        e.kind = KIND_CLOSE;
        queue_event(e);
        queue_event(segment_from(ip, port, ACK_MASK | FIN_MASK, 16'($urandom_range(19))));
        repeat (8)
            queue_event(($urandom_range(1) == 0)
                        ? segment_from(ip, port, 8'($urandom) & ~(ACK_MASK | FIN_MASK),
                                       long_len())
                        : any_event());
        if ($urandom_range(1) == 0)
            how = PEER_ACKS_FIRST;
        else
            how = ($urandom_range(1) == 0) ? PEER_FIN_ACK : PEER_FIN_ONLY;
        case (how)
            PEER_ACKS_FIRST:
            begin
                queue_event(segment_from(ip, port, (8'($urandom) | ACK_MASK) & ~FIN_MASK,
                                         long_len()));
                repeat (8)
                    queue_event(($urandom_range(1) == 0)
                                ? segment_from(ip, port, 8'($urandom) & ~FIN_MASK, long_len())
                                : any_event());
                flags = 8'($urandom) | FIN_MASK;
            end
            PEER_FIN_ACK:
                flags = 8'($urandom) | FIN_MASK | ACK_MASK;
            default:
                flags = (8'($urandom) | FIN_MASK) & ~ACK_MASK;
        endcase
        e = segment_from(ip, port, flags, long_len());
        e.rx_seq = pick_word();
        queue_event(e);
        queue_event(connect_to(pick_word(), 16'(pick_word()), pick_word()));
        repeat (12)
            queue_event(($urandom_range(1) == 0)
                        ? segment_from(ip, port, 8'($urandom), long_len())
                        : any_event());

        wait_for_drain();
        repeat (8) @(posedge clk);
        $display("checked %0d result items: %0d control segments, %0d refused connects",
                 items_checked, segments_sent, refusals);
        $display("%0d zero checksums; close sequence %s; connection states reached %b",
                 zero_sums, how.name(), states_seen[5:0]);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : tcp_client_connection_fsm_test
